/* design/smacd_pkg.sv */
package smacd_pkg;

  localparam int SLOW_LEN   = 10;
  localparam int FAST_LEN   = 3;
  localparam int PRICE_BITS = 32;

  // Fast window clamped into 1..SLOW_LEN
  localparam int FAST_W = (FAST_LEN < 1) ? 1 : ((FAST_LEN > SLOW_LEN) ? SLOW_LEN : FAST_LEN);

  localparam int PRICE_W      = 32;
  localparam int DATA_W       = (PRICE_BITS < PRICE_W) ? PRICE_BITS : PRICE_W;
  localparam int PTR_W        = $clog2(SLOW_LEN);
  localparam int FILL_W       = $clog2(SLOW_LEN + 1);
  localparam int SLOW_SUM_W   = DATA_W + $clog2(SLOW_LEN);
  localparam int FAST_SUM_W   = DATA_W + $clog2(FAST_W);
  localparam int CMP_W        = SLOW_SUM_W + $clog2(SLOW_LEN + 1);
  localparam int FAST_TOTAL_W = 34;
  localparam int SLOW_TOTAL_W = 36;
  localparam int SIGNAL_W     = 2;

  localparam logic [SIGNAL_W-1:0] SIG_NONE = 2'd0;
  localparam logic [SIGNAL_W-1:0] SIG_BUY  = 2'd1;
  localparam logic [SIGNAL_W-1:0] SIG_SELL = 2'd2;

endpackage

/* design/smacd_if.sv */
interface smacd_in_if import smacd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;

  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface smacd_out_if import smacd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    warmed_up;
  logic                    fast_leads;
  logic [SIGNAL_W-1:0]     signal;
  logic [FAST_TOTAL_W-1:0] fast_total;
  logic [SLOW_TOTAL_W-1:0] slow_total;

  modport source (output valid, output warmed_up, output fast_leads, output signal,
                  output fast_total, output slow_total, input ready);
  modport sink (input valid, input warmed_up, input fast_leads, input signal,
                input fast_total, input slow_total, output ready);
endinterface

/* design/sma_crossover_detector.sv */
// Channel   Role    Payload
// samples   sink    price
// results   source  warmed_up, fast_leads, signal, fast_total, slow_total
//
// One request per cycle sustained while the results channel is ready; each sample passes
// through the window read, the running-sum update, then the compare into the output register.
// Rate is set by the running-sum recurrence.
// Synchronous reset clears pointer, fill count, sums and relation history;
// the window memory is not cleared, entries are read only once written.
// A stalled output backs up stage by stage; empty stages still take requests.
module sma_crossover_detector import smacd_pkg::*; (
  input logic          clk,
  input logic          rst,
  smacd_in_if.sink     samples,
  smacd_out_if.source  results
);

  // window memory, two read ports (oldest entry, entry FAST_W back)
  logic [DATA_W-1:0] window_mem [SLOW_LEN];

  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  fast_addr;
  logic [FILL_W-1:0] fill;

  // stage 1: read data
  logic              s1_valid;
  logic [DATA_W-1:0] s1_price;
  logic [DATA_W-1:0] s1_old_slow;
  logic [DATA_W-1:0] s1_old_fast;
  logic              s1_sub_slow;
  logic              s1_sub_fast;
  logic              s1_warm;

  // stage 2: running sums
  logic                  s2_valid;
  logic                  s2_warm;
  logic [FAST_SUM_W-1:0] fast_sum;
  logic [SLOW_SUM_W-1:0] slow_sum;

  // stage 3: output register and relation history
  logic                    out_valid;
  logic                    out_warm;
  logic                    out_above;
  logic [SIGNAL_W-1:0]     out_signal;
  logic [FAST_TOTAL_W-1:0] out_fast_total;
  logic [SLOW_TOTAL_W-1:0] out_slow_total;
  logic                    prev_known;
  logic                    prev_above;

  logic en1, en2, en3, accept;
  logic [DATA_W-1:0] price_in;
  logic [CMP_W-1:0]  lhs, rhs;
  logic              above;
  logic [SIGNAL_W-1:0] sig_next;

  assign en3    = !out_valid || results.ready;
  assign en2    = !s2_valid || en3;
  assign en1    = !s1_valid || en2;
  assign accept = samples.valid && en1;
  assign samples.ready = en1;

  assign price_in = samples.price[DATA_W-1:0];

  always_comb begin
    if (wp >= PTR_W'(FAST_W % SLOW_LEN)) begin
      fast_addr = wp - PTR_W'(FAST_W % SLOW_LEN);
    end else begin
      fast_addr = wp + PTR_W'(SLOW_LEN - FAST_W);
    end
  end

  // write at wp and read the oldest entry from the same slot (read-before-write)
  always_ff @(posedge clk) begin
    if (accept) begin
      window_mem[wp] <= price_in;
      s1_old_slow    <= window_mem[wp];
      s1_old_fast    <= window_mem[fast_addr];
      s1_price       <= price_in;
      s1_sub_slow    <= (fill == FILL_W'(SLOW_LEN));
      s1_sub_fast    <= (fill >= FILL_W'(FAST_W));
      s1_warm        <= (fill >= FILL_W'(SLOW_LEN - 1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      fill     <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= samples.valid;
      end
      if (accept) begin
        wp <= (wp == PTR_W'(SLOW_LEN - 1)) ? '0 : wp + 1'b1;
        if (fill != FILL_W'(SLOW_LEN)) begin
          fill <= fill + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      fast_sum <= '0;
      slow_sum <= '0;
    end else if (en2) begin
      s2_valid <= s1_valid;
      if (s1_valid) begin
        s2_warm  <= s1_warm;
        slow_sum <= slow_sum + SLOW_SUM_W'(s1_price)
                    - (s1_sub_slow ? SLOW_SUM_W'(s1_old_slow) : '0);
        fast_sum <= fast_sum + FAST_SUM_W'(s1_price)
                    - (s1_sub_fast ? FAST_SUM_W'(s1_old_fast) : '0);
      end
    end
  end

  // fast/FAST_W > slow/SLOW_LEN without division
  assign lhs   = CMP_W'(fast_sum) * CMP_W'(SLOW_LEN);
  assign rhs   = CMP_W'(slow_sum) * CMP_W'(FAST_W);
  assign above = lhs > rhs;

  always_comb begin
    sig_next = SIG_NONE;
    if (prev_known && (above != prev_above)) begin
      sig_next = above ? SIG_BUY : SIG_SELL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_known <= 1'b0;
      prev_above <= 1'b0;
    end else if (en3) begin
      out_valid <= s2_valid;
      if (s2_valid) begin
        out_warm <= s2_warm;
        if (s2_warm) begin
          out_above      <= above;
          out_signal     <= sig_next;
          out_fast_total <= FAST_TOTAL_W'(fast_sum);
          out_slow_total <= SLOW_TOTAL_W'(slow_sum);
          prev_known     <= 1'b1;
          prev_above     <= above;
        end else begin
          out_above      <= 1'b0;
          out_signal     <= SIG_NONE;
          out_fast_total <= '0;
          out_slow_total <= '0;
        end
      end
    end
  end

  assign results.valid      = out_valid;
  assign results.warmed_up  = out_warm;
  assign results.fast_leads = out_above;
  assign results.signal     = out_signal;
  assign results.fast_total = out_fast_total;
  assign results.slow_total = out_slow_total;

`ifndef NO_ASSERTIONS
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(SLOW_LEN))
    else $error("fill count beyond window length");

  a_wp_range: assert property (@(posedge clk) disable iff (rst)
    wp < PTR_W'(SLOW_LEN))
    else $error("write pointer out of range");

  a_warm_zero: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.warmed_up) |->
      (!results.fast_leads && results.signal == SIG_NONE
       && results.fast_total == '0 && results.slow_total == '0))
    else $error("warm-up result carries nonzero fields");

  a_sig_dir: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.signal != SIG_NONE) |->
      ((results.signal == SIG_BUY) == results.fast_leads))
    else $error("signal direction disagrees with relation");

  a_fill_warm: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_sub_slow) |-> s1_warm)
    else $error("full window item not marked warmed up");
`endif

endmodule

/* sim/tb.sv */
module tb;
  import smacd_pkg::*;

  localparam int N_RANDOM     = 2000;
  localparam int CALM_TAIL    = 300;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [PRICE_W-1:0] TOP_PRICE = '1;
  localparam longint TOP_LEVEL = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    logic                    warmed;
    logic                    above;
    logic [SIGNAL_W-1:0]     signal;
    logic [FAST_TOTAL_W-1:0] fast_total;
    logic [SLOW_TOTAL_W-1:0] slow_total;
  } crossover_t;

  typedef struct {
    logic [PRICE_W-1:0] price;
    bit                 given;
    crossover_t         value;
  } tick_row_t;

  typedef struct {
    bit         given;
    crossover_t value;
  } hand_result_t;

  localparam crossover_t NO_RESULT = '0;
  // window full of top prices: fast and slow means tie, first full sample never signals
  localparam crossover_t FULL_OF_TOP = '{warmed: 1'b1, above: 1'b0, signal: SIG_NONE,
                                         fast_total: 34'd12884901885,
                                         slow_total: 36'd42949672950};

  logic clk;
  logic rst = 1'b1;

  smacd_in_if  samples_if ();
  smacd_out_if results_if ();

  sma_crossover_detector dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  // predictor state
  logic [DATA_W-1:0] window_q [SLOW_LEN];
  int held = 0;
  bit had_relation = 1'b0;
  bit was_above = 1'b0;

  crossover_t   due_results [$];
  hand_result_t hand_results [$];

  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  buys_seen = 0;
  int  sells_seen = 0;
  int  quiet_cycles = 0;
  int  stall_left = 0;
  bit  idle_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  function automatic crossover_t advance_averages(input logic [PRICE_W-1:0] price);
    logic [63:0] fast_sum;
    logic [63:0] slow_sum;
    bit          above;
    crossover_t  r;
    int          i;
    r = NO_RESULT;
    if (held < SLOW_LEN) begin
      window_q[held] = price[DATA_W-1:0];
      held++;
    end else begin
      for (i = 0; i < SLOW_LEN - 1; i++) window_q[i] = window_q[i+1];
      window_q[SLOW_LEN-1] = price[DATA_W-1:0];
    end
    if (held == SLOW_LEN) begin
      fast_sum = '0;
      slow_sum = '0;
      for (i = 0; i < SLOW_LEN; i++) begin
        slow_sum += 64'(window_q[i]);
        if (i >= SLOW_LEN - FAST_W) fast_sum += 64'(window_q[i]);
      end
      // cross-multiplied compare of the two means
      above = (fast_sum * 64'(SLOW_LEN)) > (slow_sum * 64'(FAST_W));
      r.warmed = 1'b1;
      r.above  = above;
      if (had_relation && above != was_above) r.signal = above ? SIG_BUY : SIG_SELL;
      had_relation = 1'b1;
      was_above    = above;
      r.fast_total = fast_sum[FAST_TOTAL_W-1:0];
      r.slow_total = slow_sum[SLOW_TOTAL_W-1:0];
    end
    return r;
  endfunction

  function automatic void compare_field(input string what, input longint unsigned want,
                                        input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
      errors++;
    end
  endfunction

  // output ready with random stall bursts
  initial results_if.ready = 1'b0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      results_if.ready <= 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      results_if.ready <= 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      results_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    crossover_t   got;
    crossover_t   want;
    crossover_t   predicted;
    hand_result_t note;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        got = '{warmed: results_if.warmed_up, above: results_if.fast_leads,
                signal: results_if.signal, fast_total: results_if.fast_total,
                slow_total: results_if.slow_total};
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result, expected none got %h", $time, got);
          errors++;
        end else begin
          want = due_results.pop_front();
          compare_field("warmed_up", want.warmed, got.warmed);
          compare_field("fast_leads", want.above, got.above);
          compare_field("signal", want.signal, got.signal);
          compare_field("fast_total", want.fast_total, got.fast_total);
          compare_field("slow_total", want.slow_total, got.slow_total);
        end
        if (got.signal == SIG_BUY) buys_seen++;
        if (got.signal == SIG_SELL) sells_seen++;
        results_seen++;
      end
      if (samples_if.valid && samples_if.ready) begin
        note = '{given: 1'b0, value: NO_RESULT};
        if (hand_results.size() != 0) note = hand_results.pop_front();
        predicted = advance_averages(samples_if.price);
        due_results.push_back(note.given ? note.value : predicted);
        items_sent++;
      end
    end
    if ((samples_if.valid && samples_if.ready) || (results_if.valid && results_if.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
      $display("sma_crossover_detector: mismatch");
      $finish;
    end
  end

  task automatic send_price(input logic [PRICE_W-1:0] p, input bit given,
                            input crossover_t value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    hand_results.push_back('{given: given, value: value});
    samples_if.valid <= 1'b1;
    samples_if.price <= p;
    @(posedge clk);
    while (!samples_if.ready) @(posedge clk);
  endtask

  task automatic drain_pipeline();
    samples_if.valid <= 1'b0;
    @(posedge clk);
    while (results_seen != items_sent) @(posedge clk);
  endtask

  initial begin
    tick_row_t          rows [$];
    logic [PRICE_W-1:0] p;
    longint             level;
    longint             drift;
    int                 n;
    int                 k;
    int                 r;
    int                 seg_len;
    int                 mode;
    int                 scale;
    bit                 up;

    samples_if.valid <= 1'b0;
    samples_if.price <= '0;

    // warm-up on top prices, then fall and rise to force a buy and a sell
    for (r = 0; r < SLOW_LEN - 1; r++)
      rows.push_back('{price: TOP_PRICE, given: 1'b1, value: NO_RESULT});
    rows.push_back('{price: TOP_PRICE,     given: 1'b1, value: FULL_OF_TOP});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: TOP_PRICE,     given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: TOP_PRICE,     given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: TOP_PRICE,     given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: '0,            given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: 32'hAAAA_AAAA, given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: 32'h5555_5555, given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: 32'h0000_0001, given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: 32'h8000_0000, given: 1'b0, value: NO_RESULT});
    rows.push_back('{price: 32'h7FFF_FFFF, given: 1'b0, value: NO_RESULT});

    @(posedge clk);
    while (rst) @(posedge clk);

    for (r = 0; r < rows.size(); r++) send_price(rows[r].price, rows[r].given, rows[r].value);

    // random part: trending segments give crossings, the rest is noise and extremes
    level = 64'h8000_0000;
    n = 0;
    while (n < N_RANDOM) begin
      seg_len = $urandom_range(20, 80);
      mode    = $urandom_range(0, 9);
      scale   = $urandom_range(2, 28);
      up      = $urandom_range(0, 1);
      drift   = longint'($urandom_range(1, 1 << scale));
      idle_on = ($urandom_range(0, 3) != 0) && (n < N_RANDOM - CALM_TAIL);
      for (k = 0; k < seg_len && n < N_RANDOM; k++) begin
        if (n == N_RANDOM / 2) drain_pipeline();
        if (n >= N_RANDOM - CALM_TAIL) idle_on = 1'b0;
        case (mode)
          6, 7: begin
            level = longint'($urandom);
          end
          8: begin
            case ($urandom_range(0, 3))
              0: level = 0;
              1: level = 1;
              2: level = TOP_LEVEL - 1;
              default: level = TOP_LEVEL;
            endcase
          end
          9: begin
            // flat: price level stays put
          end
          default: begin
            level = level + (up ? drift : -drift)
                    + longint'($urandom_range(0, 2 * drift)) - drift;
          end
        endcase
        if (level < 0) level = 0;
        if (level > TOP_LEVEL) level = TOP_LEVEL;
        p = level[PRICE_W-1:0];
        send_price(p, 1'b0, NO_RESULT);
        n++;
      end
    end

    drain_pipeline();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("fed %0d price samples, checked %0d results (%0d buy, %0d sell crossings)",
             items_sent, results_seen, buys_seen, sells_seen);
    $display("stimulus: warm-up, extreme prices, trends, flats and noise under random stalls");
    if (errors == 0 && due_results.size() == 0) begin
      $display("sma_crossover_detector: match");
    end else begin
      $display("sma_crossover_detector: mismatch");
    end
    $finish;
  end

endmodule
